>>> hw/rtl/e2g_pkg.sv
// shared types, constants and the cordic angle table for the geodetic converter
package e2g_pkg;

	typedef enum logic [3:0] {
		OP_MXX, OP_MYY, OP_SQP, OP_MZZ, OP_SQH0, OP_LON, OP_DVS, OP_MSS,
		OP_MES, OP_SQW, OP_DVN, OP_MM, OP_MD, OP_MTT, OP_SQH, OP_LAT
	} e2g_op_t;

	typedef struct packed {
		logic    start;
		e2g_op_t op;
		logic    load;
		logic    publish;
	} e2g_cmd_t;

	typedef struct packed {
		logic done;
		logic again;
	} e2g_sts_t;

	localparam logic [31:0] HALF_PI_Q30 = 32'd1686629713;
	localparam logic [32:0] PI_Q30 = 33'd3373259426;
	localparam logic signed [63:0] H_LIMIT = 64'sd8000000000;
	localparam logic signed [63:0] H_START_PREV = -64'sd100000;

	function automatic logic [29:0] atan_q30(input logic [5:0] i);
		logic [29:0] v;
		case (i)
			6'd0: v = 30'd843314857;
			6'd1: v = 30'd497837829;
			6'd2: v = 30'd263043837;
			6'd3: v = 30'd133525159;
			6'd4: v = 30'd67021687;
			6'd5: v = 30'd33543516;
			6'd6: v = 30'd16775851;
			6'd7: v = 30'd8388437;
			6'd8: v = 30'd4194283;
			6'd9: v = 30'd2097149;
			default: v = (i <= 6'd30) ? (30'd1 << (6'd30 - i)) : 30'd0;
		endcase
		return v;
	endfunction

endpackage

>>> hw/rtl/e2g_mul.sv
// sequential 64x64 multiplier built from four 32x32 partial products
module e2g_mul import e2g_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [63:0]   a,
	input  logic [63:0]   b,
	output logic          done,
	output logic [127:0]  prod
);

	logic [63:0]  a_q, b_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_q;
	logic [1:0]   psh_q;
	logic         pend_q, busy_q, done_q;
	logic [2:0]   cnt_q;
	logic [31:0]  ha, hb;

	assign ha = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign hb = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			b_q <= '0;
			acc_q <= '0;
			pp_q <= '0;
			psh_q <= '0;
			pend_q <= 1'b0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q <= a;
				b_q <= b;
				acc_q <= '0;
				cnt_q <= '0;
				pend_q <= 1'b0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (cnt_q[2] == 1'b0) begin
					pp_q <= ha * hb;
					psh_q <= 2'({1'b0, cnt_q[1]} + {1'b0, cnt_q[0]});
				end
				pend_q <= ~cnt_q[2];
				if (pend_q) begin
					acc_q <= acc_q + ({64'b0, pp_q} << {psh_q, 5'b0});
				end
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q[2]) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;

endmodule

>>> hw/rtl/e2g_sqrt.sv
// bit-serial floor square root of a 128-bit radicand
module e2g_sqrt import e2g_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [127:0]  rad,
	output logic          done,
	output logic [63:0]   root
);

	logic [127:0] rad_q;
	logic [67:0]  rem_q;
	logic [63:0]  root_q;
	logic [5:0]   cnt_q;
	logic         busy_q, done_q;
	logic [67:0]  rem_sh, trial;
	logic         ge;

	assign rem_sh = {rem_q[65:0], rad_q[127:126]};
	assign trial = {2'b0, root_q, 2'b01};
	assign ge = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rad_q <= '0;
			rem_q <= '0;
			root_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rad_q <= rad;
				rem_q <= '0;
				root_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? rem_sh - trial : rem_sh;
				root_q <= {root_q[62:0], ge};
				rad_q <= rad_q << 2;
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

>>> hw/rtl/e2g_div.sv
// restoring 128 by 64 divider, one quotient bit per cycle, low 64 quotient bits
module e2g_div import e2g_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [127:0]  num,
	input  logic [63:0]   den,
	output logic          done,
	output logic [63:0]   quo
);

	logic [127:0] num_q;
	logic [63:0]  den_q, r_q, q_q;
	logic [6:0]   cnt_q;
	logic         busy_q, done_q;
	logic [64:0]  rs, dd;
	logic         ge;

	assign rs = {r_q, num_q[127]};
	assign dd = {1'b0, den_q};
	assign ge = rs >= dd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			den_q <= '0;
			r_q <= '0;
			q_q <= '0;
			cnt_q <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= num;
				den_q <= den;
				r_q <= '0;
				q_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				r_q <= ge ? 64'(rs - dd) : rs[63:0];
				q_q <= {q_q[62:0], ge};
				num_q <= num_q << 1;
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'd127) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo = (den_q == 64'd0) ? 64'd0 : q_q;

endmodule

>>> hw/rtl/e2g_cordic.sv
// iterative vectoring cordic giving atan(num/den) in q30, clamped to [0, pi/2]
module e2g_cordic import e2g_pkg::*; #(
	parameter int STAGES = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  num,
	input  logic [63:0]  den,
	output logic         done,
	output logic [31:0]  ang
);

	localparam int CW = $clog2(STAGES);

	typedef enum logic [1:0] {CS_IDLE, CS_NORM, CS_ROT, CS_FIN} cs_t;

	cs_t                st_q;
	logic signed [63:0] x_q, y_q, dx, dy;
	logic signed [33:0] ang_q, step;
	logic [CW-1:0]      cnt_q;
	logic               done_q;
	logic [31:0]        res_q;

	assign dx = y_q >>> cnt_q;
	assign dy = x_q >>> cnt_q;
	assign step = $signed({4'b0, atan_q30(6'(cnt_q))});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CS_IDLE;
			x_q <= '0;
			y_q <= '0;
			ang_q <= '0;
			cnt_q <= '0;
			done_q <= 1'b0;
			res_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				CS_IDLE: begin
					if (start) begin
						if (num == 64'd0) begin
							res_q <= '0;
							done_q <= 1'b1;
						end else if (den == 64'd0) begin
							res_q <= HALF_PI_Q30;
							done_q <= 1'b1;
						end else begin
							x_q <= $signed(den);
							y_q <= $signed(num);
							ang_q <= '0;
							cnt_q <= '0;
							st_q <= CS_NORM;
						end
					end
				end
				CS_NORM: begin
					if ((x_q[63:58] | y_q[63:58]) == 6'd0) begin
						x_q <= x_q <<< 1;
						y_q <= y_q <<< 1;
					end else begin
						st_q <= CS_ROT;
					end
				end
				CS_ROT: begin
					if (!y_q[63]) begin
						x_q <= x_q + dx;
						y_q <= y_q - dy;
						ang_q <= ang_q + step;
					end else begin
						x_q <= x_q - dx;
						y_q <= y_q + dy;
						ang_q <= ang_q - step;
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CW'(STAGES - 1)) begin
						st_q <= CS_FIN;
					end
				end
				CS_FIN: begin
					if (ang_q[33]) begin
						res_q <= '0;
					end else if (ang_q > $signed({2'b0, HALF_PI_Q30})) begin
						res_q <= HALF_PI_Q30;
					end else begin
						res_q <= ang_q[31:0];
					end
					done_q <= 1'b1;
					st_q <= CS_IDLE;
				end
				default: st_q <= CS_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign ang = res_q;

endmodule

>>> hw/rtl/e2g_dp.sv
// datapath: working registers, shared arithmetic units and result registers
module e2g_dp import e2g_pkg::*; #(
	parameter int MAX_ITERATIONS = 15,
	parameter int CORDIC_STAGES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  e2g_cmd_t           cmd,
	output e2g_sts_t           sts,
	input  logic signed [33:0] x_mm,
	input  logic signed [33:0] y_mm,
	input  logic signed [33:0] z_mm,
	input  logic [32:0]        axis,
	input  logic [39:0]        e2,
	input  logic [16:0]        tol,
	output logic signed [31:0] latitude_q30,
	output logic signed [32:0] longitude_q30,
	output logic signed [33:0] height_mm,
	output logic               not_converged,
	output logic [3:0]         iterations_used
);

	logic signed [33:0] x_q, y_q, z_q;
	logic [33:0]        ux_q, uy_q, uz_q;
	logic [69:0]        p2_q;
	logic [127:0]       tmp_q;
	logic [34:0]        p_q;
	logic [63:0]        hyp_q, nr_q, m_q;
	logic signed [63:0] t_q, h_q, hp_q;
	logic [30:0]        s_q;
	logic [40:0]        s2_q, u_q, w_q;
	logic [3:0]         n_q;
	logic signed [32:0] lon_q;
	logic signed [31:0] lat_q;
	e2g_op_t            op_q;

	logic [63:0]  ut, dmag, d;
	logic signed [63:0] diff, zw;
	logic         over;
	logic signed [63:0] h_sat, diff_sat;
	logic [63:0]  dmag_sat;
	logic [63:0]  mul_a, mul_b, dv_den, cd_num, cd_den;
	logic [127:0] sq_rad, dv_num, prod;
	logic         mul_go, sq_go, dv_go, cd_go;
	logic         mul_done, sq_done, dv_done, cd_done, done;
	logic [63:0]  root, quo;
	logic [31:0]  ang;
	logic [32:0]  lonv;

	assign ut = t_q[63] ? 64'(-t_q) : 64'(t_q);
	assign diff = hp_q - h_q;
	assign dmag = diff[63] ? 64'(-diff) : 64'(diff);
	assign over = dmag > {47'b0, tol};
	// flag on the saturated height
	assign h_sat = (h_q > H_LIMIT) ? H_LIMIT : ((h_q < -H_LIMIT) ? -H_LIMIT : h_q);
	assign diff_sat = hp_q - h_sat;
	assign dmag_sat = diff_sat[63] ? 64'(-diff_sat) : 64'(diff_sat);
	assign zw = 64'(z_q);
	assign d = prod[93:30];
	assign lonv = x_q[33] ? PI_Q30 - {1'b0, ang} : {1'b0, ang};
	assign done = mul_done | sq_done | dv_done | cd_done;
	assign sts.done = done;
	assign sts.again = (n_q < 4'(MAX_ITERATIONS)) && over;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		sq_rad = '0;
		dv_num = '0;
		dv_den = '0;
		cd_num = '0;
		cd_den = '0;
		mul_go = 1'b0;
		sq_go = 1'b0;
		dv_go = 1'b0;
		cd_go = 1'b0;
		case (cmd.op)
			OP_MXX: begin mul_go = 1'b1; mul_a = {30'b0, ux_q}; mul_b = {30'b0, ux_q}; end
			OP_MYY: begin mul_go = 1'b1; mul_a = {30'b0, uy_q}; mul_b = {30'b0, uy_q}; end
			OP_MZZ: begin mul_go = 1'b1; mul_a = {30'b0, uz_q}; mul_b = {30'b0, uz_q}; end
			OP_MSS: begin mul_go = 1'b1; mul_a = {33'b0, s_q}; mul_b = {33'b0, s_q}; end
			OP_MES: begin mul_go = 1'b1; mul_a = {24'b0, e2}; mul_b = {23'b0, s2_q}; end
			OP_MM:  begin mul_go = 1'b1; mul_a = nr_q; mul_b = {24'b0, e2}; end
			OP_MD:  begin mul_go = 1'b1; mul_a = m_q; mul_b = {33'b0, s_q}; end
			OP_MTT: begin mul_go = 1'b1; mul_a = ut; mul_b = ut; end
			OP_SQP: begin sq_go = 1'b1; sq_rad = {58'b0, p2_q}; end
			OP_SQH0, OP_SQH: begin sq_go = 1'b1; sq_rad = tmp_q; end
			OP_SQW: begin sq_go = 1'b1; sq_rad = {47'b0, u_q, 40'b0}; end
			OP_DVS: begin dv_go = 1'b1; dv_num = {34'b0, ut, 30'b0}; dv_den = hyp_q; end
			OP_DVN: begin dv_go = 1'b1; dv_num = {55'b0, axis, 40'b0}; dv_den = {23'b0, w_q}; end
			OP_LON: begin cd_go = 1'b1; cd_num = {30'b0, uy_q}; cd_den = {30'b0, ux_q}; end
			OP_LAT: begin cd_go = 1'b1; cd_num = ut; cd_den = {29'b0, p_q}; end
			default: begin end
		endcase
	end

	e2g_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(cmd.start & mul_go),
		.a(mul_a), .b(mul_b), .done(mul_done), .prod(prod)
	);

	e2g_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(cmd.start & sq_go),
		.rad(sq_rad), .done(sq_done), .root(root)
	);

	e2g_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.start & dv_go),
		.num(dv_num), .den(dv_den), .done(dv_done), .quo(quo)
	);

	e2g_cordic #(.STAGES(CORDIC_STAGES)) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(cmd.start & cd_go),
		.num(cd_num), .den(cd_den), .done(cd_done), .ang(ang)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_MXX;
			n_q <= '0;
		end else begin
			if (cmd.start) begin
				op_q <= cmd.op;
			end
			if (cmd.load) begin
				n_q <= '0;
			end else if (done && op_q == OP_SQH) begin
				n_q <= n_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= x_mm;
			y_q <= y_mm;
			z_q <= z_mm;
			ux_q <= x_mm[33] ? 34'(-x_mm) : 34'(x_mm);
			uy_q <= y_mm[33] ? 34'(-y_mm) : 34'(y_mm);
			uz_q <= z_mm[33] ? 34'(-z_mm) : 34'(z_mm);
			t_q <= 64'(z_mm);
			h_q <= '0;
			hp_q <= H_START_PREV;
		end else if (done) begin
			case (op_q)
				OP_MXX: p2_q <= prod[69:0];
				OP_MYY: p2_q <= p2_q + prod[69:0];
				OP_SQP: p_q <= root[34:0];
				OP_MZZ, OP_MTT: tmp_q <= {58'b0, p2_q} + prod;
				OP_SQH0: hyp_q <= root;
				OP_LON: lon_q <= y_q[33] ? -$signed(lonv) : $signed(lonv);
				OP_DVS: begin
					s_q <= quo[30:0];
					hp_q <= h_q;
				end
				OP_MSS: s2_q <= prod[60:20];
				OP_MES: u_q <= {1'b1, 40'b0} - prod[80:40];
				OP_SQW: w_q <= root[40:0];
				OP_DVN: nr_q <= quo;
				OP_MM: m_q <= prod[103:40];
				OP_MD: t_q <= t_q[63] ? zw - $signed(d) : zw + $signed(d);
				OP_SQH: begin
					hyp_q <= root;
					h_q <= $signed(root - nr_q);
				end
				OP_LAT: lat_q <= t_q[63] ? -$signed(ang) : $signed(ang);
				default: begin end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			latitude_q30 <= lat_q;
			longitude_q30 <= lon_q;
			height_mm <= h_sat[33:0];
			not_converged <= dmag_sat > {47'b0, tol};
			iterations_used <= n_q;
		end
	end

endmodule

>>> hw/rtl/e2g_ctrl.sv
// controller: sequences datapath operations and runs both handshakes
module e2g_ctrl import e2g_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	output e2g_cmd_t cmd,
	input  e2g_sts_t sts
);

	typedef enum logic [1:0] {ST_IDLE, ST_WAIT, ST_CHECK, ST_FIN} st_t;

	st_t     st_q;
	e2g_op_t op_q, nxt;
	logic    start_q, out_valid_q, publish, load;

	always_comb begin
		case (op_q)
			OP_MXX: nxt = OP_MYY;
			OP_MYY: nxt = OP_SQP;
			OP_SQP: nxt = OP_MZZ;
			OP_MZZ: nxt = OP_SQH0;
			OP_SQH0: nxt = OP_LON;
			OP_DVS: nxt = OP_MSS;
			OP_MSS: nxt = OP_MES;
			OP_MES: nxt = OP_SQW;
			OP_SQW: nxt = OP_DVN;
			OP_DVN: nxt = OP_MM;
			OP_MM: nxt = OP_MD;
			OP_MD: nxt = OP_MTT;
			OP_MTT: nxt = OP_SQH;
			default: nxt = OP_LAT;
		endcase
	end

	assign load = in_valid && st_q == ST_IDLE;
	assign publish = st_q == ST_FIN && (!out_valid_q || !out_stall);
	assign in_stall = st_q != ST_IDLE;
	assign out_valid = out_valid_q;
	assign cmd.start = start_q;
	assign cmd.op = op_q;
	assign cmd.load = load;
	assign cmd.publish = publish;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			op_q <= OP_MXX;
			start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_valid) begin
						op_q <= OP_MXX;
						start_q <= 1'b1;
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (sts.done) begin
						if (op_q == OP_LON || op_q == OP_SQH) begin
							st_q <= ST_CHECK;
						end else if (op_q == OP_LAT) begin
							st_q <= ST_FIN;
						end else begin
							op_q <= nxt;
							start_q <= 1'b1;
						end
					end
				end
				ST_CHECK: begin
					op_q <= sts.again ? OP_DVS : OP_LAT;
					start_q <= 1'b1;
					st_q <= ST_WAIT;
				end
				ST_FIN: begin
					if (publish) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/ecef_to_geodetic_top.sv
// top level of the earth-centred cartesian to geodetic converter
//
//   channel   direction  handshake            payload
//   in        input      in_valid/in_stall    x_mm, y_mm, z_mm
//   out       output     out_valid/out_stall  latitude_q30, longitude_q30, height_mm,
//                                             not_converged, iterations_used
//   cfg       input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one position at a time: run time grows with STAGES and with every refinement pass,
// and the cordic first normalizes each operand pair;
// the bit-serial divider and square root unit set most of it
// a result sits in the output register while the next position is taken in
// reset brings the ellipsoid registers to wgs84 and empties the block
// out_stall holds the result; the next one waits until it is taken
module ecef_to_geodetic_top import e2g_pkg::*; #(
	parameter int MAX_ITERATIONS = 15,
	parameter int CORDIC_STAGES = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [33:0] x_mm,
	input  logic signed [33:0] y_mm,
	input  logic signed [33:0] z_mm,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] latitude_q30,
	output logic signed [32:0] longitude_q30,
	output logic signed [33:0] height_mm,
	output logic               not_converged,
	output logic [3:0]         iterations_used,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [39:0]        cfg_data
);

	localparam logic [1:0] REG_AXIS = 2'd0;
	localparam logic [1:0] REG_ECC2 = 2'd1;
	localparam logic [1:0] REG_TOL = 2'd2;

	logic [32:0] axis_q;
	logic [39:0] e2_q;
	logic [16:0] tol_q;
	e2g_cmd_t    cmd;
	e2g_sts_t    sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= 33'd6378137000;
			e2_q <= 40'd7360548640;
			tol_q <= 17'd100;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AXIS: axis_q <= cfg_data[32:0];
				REG_ECC2: e2_q <= cfg_data;
				REG_TOL: tol_q <= cfg_data[16:0];
				default: begin end
			endcase
		end
	end

	e2g_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .sts(sts)
	);

	e2g_dp #(
		.MAX_ITERATIONS(MAX_ITERATIONS),
		.CORDIC_STAGES(CORDIC_STAGES)
	) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.x_mm(x_mm), .y_mm(y_mm), .z_mm(z_mm),
		.axis(axis_q), .e2(e2_q), .tol(tol_q),
		.latitude_q30(latitude_q30), .longitude_q30(longitude_q30),
		.height_mm(height_mm), .not_converged(not_converged),
		.iterations_used(iterations_used)
	);

endmodule

>>> test/tb.sv
// self-checking testbench for the cartesian to geodetic converter
module tb;
	import e2g_pkg::*;

	localparam int PASS_CAP = 15;
	localparam int ANGLE_STAGES = 32;
	localparam int QUIET_LIMIT = 60000;
	localparam logic [1:0] REG_AXIS = 2'd0;
	localparam logic [1:0] REG_ECC = 2'd1;
	localparam logic [1:0] REG_TOL = 2'd2;
	localparam longint WGS_AXIS = 64'd6378137000;
	localparam longint WGS_ECC = 64'd7360548640;
	localparam longint ANGLE_HEAD [10] = '{843314857, 497837829, 263043837, 133525159,
		67021687, 33543516, 16775851, 8388437, 4194283, 2097149};

	typedef struct {
		logic signed [31:0] lat;
		logic signed [32:0] lon;
		logic signed [33:0] h;
		logic               nc;
		logic [3:0]         it;
	} geo_t;

	typedef struct {
		logic signed [33:0] x;
		logic signed [33:0] y;
		logic signed [33:0] z;
		bit                 typed;
		geo_t               want;
	} probe_t;

	typedef struct {
		longint axis;
		longint ecc;
		longint tol;
		int     count;
	} setting_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [33:0] x_mm = '0;
	logic signed [33:0] y_mm = '0;
	logic signed [33:0] z_mm = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] latitude_q30;
	logic signed [32:0] longitude_q30;
	logic signed [33:0] height_mm;
	logic not_converged;
	logic [3:0] iterations_used;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [39:0] cfg_data = '0;

	logic [63:0] axis_mm;
	logic [63:0] ecc_q40;
	logic [63:0] tol_mm;
	geo_t fixes_due [$];
	int errors = 0;
	int quiet_cycles = 0;
	bit jitter = 1'b1;

	ecef_to_geodetic_top dut (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] root128(logic [127:0] v);
		logic [63:0] r, c;
		r = '0;
		for (int b = 63; b >= 0; b--) begin
			c = r | (64'd1 << b);
			if ({64'd0, c} * {64'd0, c} <= v)
				r = c;
		end
		return r;
	endfunction

	function automatic logic [63:0] quot128(logic [127:0] n, logic [63:0] d);
		logic [127:0] q;
		if (d == 0)
			return '0;
		q = n / {64'd0, d};
		return q[63:0];
	endfunction

	function automatic logic [63:0] mag64(longint v);
		longint a;
		a = v < 0 ? -v : v;
		return 64'(a);
	endfunction

	function automatic longint angle_step(int i);
		if (i < 10)
			return ANGLE_HEAD[i];
		if (i <= 30)
			return longint'(1) << (30 - i);
		return 0;
	endfunction

	// vectoring cordic, first quadrant only
	function automatic longint vector_angle(logic [63:0] num, logic [63:0] den);
		longint x, y, ang, dx, dy;
		logic [63:0] nn, dd;
		if (num == 0)
			return 0;
		if (den == 0)
			return longint'(HALF_PI_Q30);
		nn = num;
		dd = den;
		while ((nn | dd) < (64'd1 << 58)) begin
			nn = nn << 1;
			dd = dd << 1;
		end
		x = longint'(dd);
		y = longint'(nn);
		ang = 0;
		for (int i = 0; i < ANGLE_STAGES && i < 40; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx;
				y -= dy;
				ang += angle_step(i);
			end else begin
				x -= dx;
				y += dy;
				ang -= angle_step(i);
			end
		end
		if (ang < 0)
			ang = 0;
		if (ang > longint'(HALF_PI_Q30))
			ang = longint'(HALF_PI_Q30);
		return ang;
	endfunction

	function automatic geo_t geodetic_fix(logic signed [33:0] x, logic signed [33:0] y,
			logic signed [33:0] z);
		longint xs, ys, zs, lon, lat, t, h, hp, a0;
		logic [63:0] ux, uy, ut, s, s2, u, w, nr, m, d, hyp, p;
		logic [127:0] p2, tmp;
		int n;
		geo_t f;
		xs = x;
		ys = y;
		zs = z;
		ux = mag64(xs);
		uy = mag64(ys);
		p2 = {64'd0, ux} * {64'd0, ux} + {64'd0, uy} * {64'd0, uy};
		p = root128(p2);
		ut = mag64(zs);
		hyp = root128(p2 + {64'd0, ut} * {64'd0, ut});
		a0 = vector_angle(uy, ux);
		lon = xs >= 0 ? a0 : longint'(PI_Q30) - a0;
		if (ys < 0)
			lon = -lon;
		t = zs;
		h = 0;
		hp = H_START_PREV;
		n = 0;
		while (n < PASS_CAP && mag64(hp - h) > tol_mm) begin
			hp = h;
			ut = mag64(t);
			s = quot128({64'd0, ut} << 30, hyp);
			s2 = (s * s) >> 20;
			tmp = ({64'd0, ecc_q40} * {64'd0, s2}) >> 40;
			u = (64'd1 << 40) - tmp[63:0];
			w = root128({64'd0, u} << 40);
			nr = quot128({64'd0, axis_mm} << 40, w);
			tmp = ({64'd0, nr} * {64'd0, ecc_q40}) >> 40;
			m = tmp[63:0];
			tmp = ({64'd0, m} * {64'd0, s}) >> 30;
			d = tmp[63:0];
			t = t < 0 ? zs - longint'(d) : zs + longint'(d);
			ut = mag64(t);
			hyp = root128(p2 + {64'd0, ut} * {64'd0, ut});
			h = longint'(hyp) - longint'(nr);
			n++;
		end
		lat = vector_angle(mag64(t), p);
		if (t < 0)
			lat = -lat;
		if (h > H_LIMIT)
			h = H_LIMIT;
		if (h < -H_LIMIT)
			h = -H_LIMIT;
		f.lat = 32'(lat);
		f.lon = 33'(lon);
		f.h = 34'(h);
		f.nc = mag64(hp - h) > tol_mm;
		f.it = 4'(n);
		return f;
	endfunction

	function automatic logic signed [33:0] rand_coord(bit full);
		logic [63:0] v;
		v = {$urandom, $urandom};
		if (full)
			return v[33:0];
		return 34'(longint'(v % 64'd12800000001) - 64'sd6400000000);
	endfunction

	task automatic send_fix(logic signed [33:0] x, logic signed [33:0] y,
			logic signed [33:0] z, bit typed, geo_t want);
		if (jitter && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			do @(posedge clk); while (jitter && $urandom_range(99) < 31);
		end
		x_mm <= x;
		y_mm <= y;
		z_mm <= z;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		fixes_due.push_back(typed ? want : geodetic_fix(x, y, z));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (fixes_due.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [39:0] data);
		@(posedge clk);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_AXIS: axis_mm = {31'd0, data[32:0]};
			REG_ECC:  ecc_q40 = {24'd0, data};
			REG_TOL:  tol_mm = {47'd0, data[16:0]};
			default: ;
		endcase
	endtask

	always @(posedge clk)
		out_stall <= jitter && ($urandom_range(99) < 31);

	always @(posedge clk) begin
		geo_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (fixes_due.size() == 0) begin
				$display("%0t: result with nothing expected", $time);
				errors++;
			end else begin
				e = fixes_due.pop_front();
				if (latitude_q30 !== e.lat) begin
					$display("%0t: latitude exp %0d got %0d", $time, e.lat, latitude_q30);
					errors++;
				end
				if (longitude_q30 !== e.lon) begin
					$display("%0t: longitude exp %0d got %0d", $time, e.lon, longitude_q30);
					errors++;
				end
				if (height_mm !== e.h) begin
					$display("%0t: height exp %0d got %0d", $time, e.h, height_mm);
					errors++;
				end
				if (not_converged !== e.nc) begin
					$display("%0t: not_converged exp %0d got %0d", $time, e.nc,
						not_converged);
					errors++;
				end
				if (iterations_used !== e.it) begin
					$display("%0t: iterations exp %0d got %0d", $time, e.it,
						iterations_used);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else if (quiet_cycles >= QUIET_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		probe_t probes [$];
		setting_t phases [$];
		geo_t none;
		logic signed [33:0] c [3];
		int r;
		none = '{0, 0, 0, 0, 0};
		axis_mm = WGS_AXIS;
		ecc_q40 = WGS_ECC;
		tol_mm = 100;
		probes = '{
			'{34'sd0, 34'sd0, 34'sd0, 1, '{0, 0, -34'sd6378137000, 0, 4'd2}},
			'{34'sd6378137000, 34'sd0, 34'sd0, 1, '{0, 0, 0, 0, 4'd1}},
			'{-34'sd6378137000, 34'sd0, 34'sd0, 1, '{0, PI_Q30, 0, 0, 4'd1}},
			'{34'sd0, 34'sd6378137000, 34'sd0, 0, none},
			'{34'sd0, -34'sd6378137000, 34'sd0, 0, none},
			'{34'sd0, 34'sd0, 34'sd6356752314, 0, none},
			'{34'sd0, 34'sd0, -34'sd6356752314, 0, none},
			'{34'sd0, 34'sd0, 34'sd1, 0, none},
			'{-34'sd1, 34'sd0, 34'sd0, 0, none},
			'{-34'sd1, -34'sd1, -34'sd1, 0, none},
			'{34'sd8589934591, 34'sd8589934591, 34'sd8589934591, 0, none},
			'{-34'sd8589934592, -34'sd8589934592, -34'sd8589934592, 0, none},
			'{34'sd8000000000, -34'sd8000000000, 34'sd8000000000, 0, none},
			'{-34'sd8000000000, 34'sd8000000000, -34'sd8000000000, 0, none},
			'{34'sd3000000000, -34'sd4000000000, 34'sd4500000000, 0, none},
			'{34'sd4510731000, 34'sd4510731000, 34'sd0, 0, none}
		};
		phases = '{
			'{WGS_AXIS, WGS_ECC, 100, 480},
			'{64'd6000000000, 0, 1, 200},
			'{64'd7000000000, 64'hFF_FFFF_FFFF, 100000, 200},
			'{64'h1_FFFF_FFFF, WGS_ECC, 0, 180},
			'{WGS_AXIS, 64'd549755813888, 131071, 150},
			'{WGS_AXIS, WGS_ECC, 100, 270}
		};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (probes[i])
			send_fix(probes[i].x, probes[i].y, probes[i].z, probes[i].typed, probes[i].want);
		foreach (phases[p]) begin
			if (p != 0) begin
				drain();
				write_reg(REG_AXIS, phases[p].axis[39:0]);
				write_reg(REG_ECC, phases[p].ecc[39:0]);
				write_reg(REG_TOL, phases[p].tol[39:0]);
			end
			for (int k = 0; k < phases[p].count; k++) begin
				// steady stretch with no bubbles on either side
				jitter = !(p == 0 && k >= 100 && k < 400);
				r = $urandom_range(99);
				foreach (c[j])
					c[j] = rand_coord(r < 10);
				if (r >= 10 && r < 25)
					c[$urandom_range(2)] = '0;
				else if (r >= 25 && r < 30) begin
					c[0] = '0;
					c[1] = '0;
				end
				send_fix(c[0], c[1], c[2], 0, none);
			end
		end
		drain();
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> sim.f
hw/rtl/e2g_pkg.sv
hw/rtl/e2g_mul.sv
hw/rtl/e2g_sqrt.sv
hw/rtl/e2g_div.sv
hw/rtl/e2g_cordic.sv
hw/rtl/e2g_dp.sv
hw/rtl/e2g_ctrl.sv
hw/rtl/ecef_to_geodetic_top.sv
test/tb.sv
